>>> rtl/iak_pkg.sv
// ----------------------------------------------------------------------------
// iak_pkg
// types, constants and aes helper functions for the iterated key transform
// ----------------------------------------------------------------------------
package iak_pkg;

   localparam int WordWidth  = 64;
   localparam int BlockWidth = 128;
   localparam int KeyWidth   = 256;
   localparam int RoundNum   = 14;
   localparam int CsrIdxWidth = 3;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_ROUND_COUNT = 3'd0,
      REG_KEY_WORD_0  = 3'd1,
      REG_KEY_WORD_1  = 3'd2,
      REG_KEY_WORD_2  = 3'd3,
      REG_KEY_WORD_3  = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic [WordWidth-1:0] data_word_0;
      logic [WordWidth-1:0] data_word_1;
      logic [WordWidth-1:0] data_word_2;
      logic [WordWidth-1:0] data_word_3;
   } req_type;

   typedef struct packed {
      logic [WordWidth-1:0] out_word_0;
      logic [WordWidth-1:0] out_word_1;
      logic [WordWidth-1:0] out_word_2;
      logic [WordWidth-1:0] out_word_3;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic key_init;
      logic key_step;
      logic key_even;
      logic blk_init;
      logic blk_round;
      logic blk_last;
   } cmd_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of the state sits at bits [127-8i -: 8]
   function automatic logic [BlockWidth-1:0] aes_round(input logic [BlockWidth-1:0] s,
                                                         input logic last);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, al;
      logic [BlockWidth-1:0] r;
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            t[k + 4*c] = sbox(s[BlockWidth-1-8*(k + 4*((c + k) % 4)) -: 8]);
         end
      end
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) begin
         r[BlockWidth-1-8*i -: 8] = t[i];
      end
      return r;
   endfunction

endpackage

>>> rtl/iak_datapath.sv
// ----------------------------------------------------------------------------
// iak_datapath
// two aes state registers sharing one rolling 256-bit round key window
// ----------------------------------------------------------------------------
module iak_datapath (
   input  logic                          clock,
   input  iak_pkg::cmd_type              cmd,
   input  logic [iak_pkg::KeyWidth-1:0]  key_seed,
   input  logic [7:0]                    rcon,
   input  iak_pkg::req_type              req_data,
   output iak_pkg::rsp_type              rsp_data
);

   // window holds round keys 2r and 2r+1; even rounds use the upper half
   logic [iak_pkg::KeyWidth-1:0]   key_ff, key_in;
   logic [iak_pkg::BlockWidth-1:0] left_ff, left_in, right_ff, right_in;
   logic [iak_pkg::BlockWidth-1:0] rkey;
   logic [31:0] w0, w1, w2, w3, w4, w5, w6, w7, t;

   assign rkey = cmd.key_even ? key_ff[255:128] : key_ff[127:0];

   always_comb begin
      t  = iak_pkg::sub_word({key_ff[23:0], key_ff[31:24]}) ^ {rcon, 24'h0};
      w0 = key_ff[255:224] ^ t;
      w1 = key_ff[223:192] ^ w0;
      w2 = key_ff[191:160] ^ w1;
      w3 = key_ff[159:128] ^ w2;
      w4 = key_ff[127:96] ^ iak_pkg::sub_word(w3);
      w5 = key_ff[95:64] ^ w4;
      w6 = key_ff[63:32] ^ w5;
      w7 = key_ff[31:0] ^ w6;
      key_in = key_ff;
      if (cmd.key_init) begin
         key_in = key_seed;
      end else if (cmd.key_step) begin
         key_in = {w0, w1, w2, w3, w4, w5, w6, w7};
      end
   end

   always_comb begin
      left_in  = left_ff;
      right_in = right_ff;
      if (cmd.load) begin
         left_in  = {req_data.data_word_0, req_data.data_word_1};
         right_in = {req_data.data_word_2, req_data.data_word_3};
      end else if (cmd.blk_init) begin
         left_in  = left_ff ^ rkey;
         right_in = right_ff ^ rkey;
      end else if (cmd.blk_round) begin
         left_in  = iak_pkg::aes_round(left_ff, cmd.blk_last) ^ rkey;
         right_in = iak_pkg::aes_round(right_ff, cmd.blk_last) ^ rkey;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   assign rsp_data = {left_ff, right_ff};

endmodule

>>> rtl/iak_controller.sv
// ----------------------------------------------------------------------------
// iak_controller
// sequences key window, aes rounds and the encryption count
// ----------------------------------------------------------------------------
module iak_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [iak_pkg::WordWidth-1:0] round_count,
   output iak_pkg::cmd_type              cmd,
   output logic [7:0]                    rcon
);

   typedef enum logic [1:0] {IDLE, START, ROUND, DONE} state_type;

   state_type                      state_ff, state_in;
   logic [iak_pkg::WordWidth-1:0]  left_ff, left_in;
   logic [3:0]                     rnd_ff, rnd_in;
   logic [7:0]                     rcon_ff, rcon_in;

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = (state_ff == DONE);
   assign rcon      = rcon_ff;

   always_comb begin
      state_in = state_ff;
      left_in  = left_ff;
      rnd_in   = rnd_ff;
      rcon_in  = rcon_ff;
      cmd      = '0;
      cmd.key_even = ~rnd_ff[0];
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               left_in  = round_count;
               state_in = (round_count == '0) ? DONE : START;
            end
         end
         START: begin
            cmd.key_init = 1'b1;
            rnd_in   = 4'd0;
            rcon_in  = 8'h01;
            state_in = ROUND;
         end
         ROUND: begin
            if (rnd_ff == 4'd0) begin
               cmd.blk_init = 1'b1;
            end else begin
               cmd.blk_round = 1'b1;
               cmd.blk_last  = (rnd_ff == 4'(iak_pkg::RoundNum));
            end
            if (rnd_ff[0]) begin
               cmd.key_step = 1'b1;
               rcon_in = {rcon_ff[6:0], 1'b0};
            end
            rnd_in = rnd_ff + 4'd1;
            if (rnd_ff == 4'(iak_pkg::RoundNum)) begin
               left_in = left_ff - 64'd1;
               if (left_ff == 64'd1) begin
                  state_in = DONE;
               end else begin
                  state_in = START;
               end
            end
         end
         DONE: begin
            if (rsp_ready) begin
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         left_ff  <= '0;
         rnd_ff   <= '0;
         rcon_ff  <= '0;
      end else begin
         state_ff <= state_in;
         left_ff  <= left_in;
         rnd_ff   <= rnd_in;
         rcon_ff  <= rcon_in;
      end
   end

endmodule

>>> rtl/iterated_aes256_key_transform_top.sv
// a request transfer starts the encryptions; the response is held until taken
// zero rounds: the request is returned unchanged
// one item at a time: a new request is taken only after the response transfer;
// each aes encryption is a key reload plus 15 round steps, both halves in parallel
// synchronous active-high reset clears control and all csr registers
// ----------------------------------------------------------------------------
// iterated_aes256_key_transform_top
// repeated aes-256 ecb encryption of two 128-bit halves
// ----------------------------------------------------------------------------
module iterated_aes256_key_transform_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  iak_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output iak_pkg::rsp_type                rsp_data,
   input  logic                            csr_write,
   input  logic [iak_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [iak_pkg::WordWidth-1:0]   csr_data
);

   logic [iak_pkg::WordWidth-1:0] rounds_ff, kw0_ff, kw1_ff, kw2_ff, kw3_ff;
   iak_pkg::cmd_type              cmd;
   logic [7:0]                    rcon;

   always_ff @(posedge clock) begin
      if (reset) begin
         rounds_ff <= '0;
         kw0_ff    <= '0;
         kw1_ff    <= '0;
         kw2_ff    <= '0;
         kw3_ff    <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            iak_pkg::REG_ROUND_COUNT: rounds_ff <= csr_data;
            iak_pkg::REG_KEY_WORD_0:  kw0_ff    <= csr_data;
            iak_pkg::REG_KEY_WORD_1:  kw1_ff    <= csr_data;
            iak_pkg::REG_KEY_WORD_2:  kw2_ff    <= csr_data;
            iak_pkg::REG_KEY_WORD_3:  kw3_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   iak_controller u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .round_count (rounds_ff),
      .cmd         (cmd),
      .rcon        (rcon)
   );

   iak_datapath u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .key_seed ({kw0_ff, kw1_ff, kw2_ff, kw3_ff}),
      .rcon     (rcon),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

>>> rtl/iak_checker.sv
// ----------------------------------------------------------------------------
// iak_checker
// port-level checks of the transform's handshakes
// ----------------------------------------------------------------------------
module iak_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input iak_pkg::rsp_type rsp_data
);

   // never ready for a new request while a response is pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready)) else $error("ready while response pending");

   // a request transfer is followed by busy, never an immediate ready
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("ready after transfer");

   // response transfer frees the block
   a_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> (req_ready && !rsp_valid)) else $error("not freed");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("response dropped");

endmodule

bind iterated_aes256_key_transform_top iak_checker u_iak_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> tb/sv/iterated_aes256_key_transform_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iterated_aes256_key_transform_top_tb
// self-checking bench for the iterated aes-256 key transform: a scoreboard
// class predicts each buffer by repeated aes-256 encryption of both halves
// under the programmed key seed; random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module iterated_aes256_key_transform_top_tb;

   localparam int IdleLimit = 5000;
   localparam int FirstUnusedReg = 5;
   localparam int LastRegIndex = 7;
   localparam int DrainCycles = 40;

   localparam bit [7:0] SUB_BYTES [256] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16};

   class transform_scoreboard;
      bit [63:0] round_cnt;
      bit [63:0] key_seed [4];
      bit [31:0] round_keys [60];
      iak_pkg::rsp_type pending [$];
      int        errors;

      function void write_reg(int idx, bit [63:0] value);
         case (idx)
            iak_pkg::REG_ROUND_COUNT: round_cnt = value;
            iak_pkg::REG_KEY_WORD_0:  key_seed[0] = value;
            iak_pkg::REG_KEY_WORD_1:  key_seed[1] = value;
            iak_pkg::REG_KEY_WORD_2:  key_seed[2] = value;
            iak_pkg::REG_KEY_WORD_3:  key_seed[3] = value;
            default: ;
         endcase
      endfunction

      function bit [31:0] sub4(bit [31:0] w);
         return {SUB_BYTES[w[31:24]], SUB_BYTES[w[23:16]], SUB_BYTES[w[15:8]],
                 SUB_BYTES[w[7:0]]};
      endfunction

      function bit [7:0] dbl(bit [7:0] x);
         return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
      endfunction

      function void expand_schedule();
         bit [31:0] t;
         for (int i = 0; i < 8; i++) round_keys[i] = key_seed[i/2][(i%2 ? 31 : 63) -: 32];
         for (int i = 8; i < 60; i++) begin
            t = round_keys[i-1];
            if (i % 8 == 0) t = sub4({t[23:0], t[31:24]}) ^ {8'h01 << (i/8 - 1), 24'h0};
            else if (i % 8 == 4) t = sub4(t);
            round_keys[i] = round_keys[i-8] ^ t;
         end
      endfunction

      function bit [127:0] encrypt_block(bit [127:0] s);
         bit [7:0] b [16];
         bit [7:0] t [16];
         bit [7:0] a0, a1, a2, a3, al;
         bit [127:0] r;
         for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
         for (int rnd = 0; rnd <= 14; rnd++) begin
            if (rnd > 0) begin
               for (int c = 0; c < 4; c++)
                  for (int k = 0; k < 4; k++) t[k+4*c] = SUB_BYTES[b[k+4*((c+k)%4)]];
               if (rnd != 14) begin
                  for (int c = 0; c < 4; c++) begin
                     a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                     al = a0 ^ a1 ^ a2 ^ a3;
                     t[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
                     t[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
                     t[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
                     t[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
                  end
               end
               b = t;
            end
            for (int c = 0; c < 4; c++)
               for (int k = 0; k < 4; k++) b[4*c+k] ^= round_keys[rnd*4+c][31-8*k -: 8];
         end
         for (int i = 0; i < 16; i++) r[127-8*i -: 8] = b[i];
         return r;
      endfunction

      function void note_request(iak_pkg::req_type q);
         bit [127:0] lh, rh;
         iak_pkg::rsp_type e;
         expand_schedule();
         lh = {q.data_word_0, q.data_word_1};
         rh = {q.data_word_2, q.data_word_3};
         for (bit [63:0] n = 0; n < round_cnt; n++) begin
            lh = encrypt_block(lh);
            rh = encrypt_block(rh);
         end
         {e.out_word_0, e.out_word_1} = lh;
         {e.out_word_2, e.out_word_3} = rh;
         pending.push_back(e);
      endfunction

      function void check_response(iak_pkg::rsp_type a);
         iak_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %h", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.out_word_0 !== e.out_word_0) begin
            $display("%0t: out_word_0 expected %h actual %h", $time, e.out_word_0, a.out_word_0);
            errors++;
         end
         if (a.out_word_1 !== e.out_word_1) begin
            $display("%0t: out_word_1 expected %h actual %h", $time, e.out_word_1, a.out_word_1);
            errors++;
         end
         if (a.out_word_2 !== e.out_word_2) begin
            $display("%0t: out_word_2 expected %h actual %h", $time, e.out_word_2, a.out_word_2);
            errors++;
         end
         if (a.out_word_3 !== e.out_word_3) begin
            $display("%0t: out_word_3 expected %h actual %h", $time, e.out_word_3, a.out_word_3);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   iak_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   iak_pkg::rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [iak_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [iak_pkg::WordWidth-1:0] csr_data = '0;

   transform_scoreboard board = new();
   int idle_cycles = 0;
   bit calm = 1'b0;

   iterated_aes256_key_transform_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic bit [63:0] rand_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // transfer monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (req_valid && req_ready) board.note_request(req_data);
         if (rsp_valid && rsp_ready) board.check_response(rsp_data);
         if (idle_cycles >= IdleLimit) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // receiver stalls
   initial begin
      int g;
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         g = gap_len();
         if (g > 0) begin
            rsp_ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
   end

   task automatic write_reg(int idx, bit [63:0] value);
      csr_write <= 1'b1;
      csr_index <= idx[iak_pkg::CsrIdxWidth-1:0];
      csr_data <= value;
      board.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic program_regs(bit [63:0] rc, bit [63:0] k0, bit [63:0] k1,
                               bit [63:0] k2, bit [63:0] k3);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_reg(iak_pkg::REG_ROUND_COUNT, rc);
      write_reg(iak_pkg::REG_KEY_WORD_0, k0);
      write_reg(iak_pkg::REG_KEY_WORD_1, k1);
      write_reg(iak_pkg::REG_KEY_WORD_2, k2);
      write_reg(iak_pkg::REG_KEY_WORD_3, k3);
      if ($urandom_range(0, 2) == 0)
         write_reg($urandom_range(FirstUnusedReg, LastRegIndex), {$urandom, $urandom});
      csr_write <= 1'b0;
   endtask

   task automatic send(bit [63:0] w0, bit [63:0] w1, bit [63:0] w2, bit [63:0] w3);
      int g;
      req_valid <= 1'b1;
      req_data <= '{w0, w1, w2, w3};
      do @(posedge clock); while (!req_ready);
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic close_burst();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      bit [63:0] rc;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset state: zero rounds, input returned unchanged
      send('0, '0, '0, '0);
      send('1, '1, '1, '1);
      send(64'h0123456789abcdef, 64'hfedcba9876543210, 64'h8000000000000001,
           64'h5555aaaa5555aaaa);
      close_burst();

      // standard aes-256 vector in both halves, one encryption
      program_regs(1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                   64'h1011121314151617, 64'h18191a1b1c1d1e1f);
      send(64'h0011223344556677, 64'h8899aabbccddeeff, 64'h0011223344556677,
           64'h8899aabbccddeeff);
      send('0, '0, '1, '1);
      send('1, '0, '0, '1);
      close_burst();

      program_regs(1, '1, '1, '1, '1);
      send('0, '0, '0, '0);
      send('1, '1, '1, '1);
      close_burst();

      program_regs(0, '1, '0, '1, '0);
      send('1, '0, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
      close_burst();

      program_regs(2, rand_word(), rand_word(), rand_word(), rand_word());
      send(rand_word(), rand_word(), rand_word(), rand_word());
      send(rand_word(), rand_word(), rand_word(), rand_word());
      close_burst();

      // long chain of encryptions
      program_regs(40, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom});
      send('0, '1, {$urandom, $urandom}, {$urandom, $urandom});
      close_burst();

      for (int ph = 0; ph < 12; ph++) begin
         case ($urandom_range(0, 9))
            0: rc = 0;
            1: rc = $urandom_range(8, 20);
            default: rc = $urandom_range(1, 4);
         endcase
         program_regs(rc, rand_word(), rand_word(), rand_word(), rand_word());
         calm = (ph % 4 == 3);
         repeat ($urandom_range(6, 10))
            send(rand_word(), rand_word(), rand_word(), rand_word());
         close_burst();
      end
      calm = 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (board.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
